[sv/bqf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_pkg
// Widths, register codes, sequencer types and rounding for the biquad filter.
// ----------------------------------------------------------------------------
package bqf_pkg;

   localparam int SAMPLE_WIDTH   = 24;
   localparam int COEF_WIDTH     = 24;
   localparam int COEF_FRAC_BITS = 22;
   localparam int STATE_WIDTH    = 32;
   localparam int PROD_WIDTH     = STATE_WIDTH + COEF_WIDTH;
   // three products plus guard
   localparam int ACC_WIDTH      = PROD_WIDTH + 2;
   localparam int RND_WIDTH      = ACC_WIDTH - COEF_FRAC_BITS;
   localparam int CSR_IDX_WIDTH  = 3;

   // 1.0 in coefficient format
   localparam logic signed [COEF_WIDTH-1:0] COEF_ONE =
      {{(COEF_WIDTH-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};

   localparam logic signed [ACC_WIDTH-1:0] ACC_HALF =
      {{(ACC_WIDTH-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

   localparam logic signed [RND_WIDTH-1:0] W_MAX =
      {{(RND_WIDTH-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
   localparam logic signed [RND_WIDTH-1:0] W_MIN = ~W_MAX;
   localparam logic signed [RND_WIDTH-1:0] Y_MAX =
      {{(RND_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [RND_WIDTH-1:0] Y_MIN = ~Y_MAX;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_A1 = 3'd0,
      CSR_A2 = 3'd1,
      CSR_B0 = 3'd2,
      CSR_B1 = 3'd3,
      CSR_B2 = 3'd4
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_W0, S_W1, S_W2, S_W3, S_WR,
      S_Y0, S_Y1, S_Y2, S_Y3, S_YR
   } state_type;

   typedef enum logic [1:0] {
      A_X, A_W1, A_W2, A_W
   } a_sel_type;

   typedef enum logic [2:0] {
      B_ONE, B_A1, B_A2, B_B0, B_B1, B_B2
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB
   } acc_op_type;

   typedef struct packed {
      a_sel_type  a_sel;
      b_sel_type  b_sel;
      acc_op_type acc_op;
      logic       w_done;   // acc holds the w sum
      logic       y_done;   // acc holds the y sum, result loads now
   } seq_ctl_type;

   // round to nearest (tie toward +inf), drop the coefficient fraction bits
   function automatic logic signed [RND_WIDTH-1:0] round_acc(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-1:0] sum;
      sum = acc + ACC_HALF;
      return signed'(sum[ACC_WIDTH-1:COEF_FRAC_BITS]);
   endfunction

endpackage

[sv/biquad_iir_df2_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// biquad_iir_df2_filter
// Direct form II biquad, one shared 32x24 multiplier, coefficients by CSR.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel: one audio sample (Q1.23) and a block end marker per beat.
//   rsp_ channel: filtered sample, marker copy and a clip flag per beat.
//   csr_ port:    write-only; index 0..4 = a1, a2, b0, b1, b2 (Q2.22).
//                 Other indexes are dropped. Write only while idle.
// Timing:
//   One request beat is followed by exactly one response beat. rsp_valid
//   is registered: it rises after the y rounding step loads the result.
//   The MAC sequencer runs three products, a pipeline drain and a rounding
//   step for each of w and y, and a new sample is taken only once all 10
//   MAC steps are done and the sequencer is back in idle.
//   The response sits in an output register; the next sample is accepted
//   while it waits. If the receiver still stalls when the next result is
//   done, the sequencer holds that result until the register frees up.
// Reset:
//   Clears both delay-line w values, sets coefficients to pass-through
//   (b0 = 1.0, the rest 0) and empties the output register.
// ----------------------------------------------------------------------------
module biquad_iir_df2_filter (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]     req_sample_in,
   input  logic                                        req_block_end_in,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic signed [bqf_pkg::SAMPLE_WIDTH-1:0]     rsp_sample_out,
   output logic                                        rsp_block_end_out,
   output logic                                        rsp_clipped,
   input  logic                                        csr_we,
   input  logic [bqf_pkg::CSR_IDX_WIDTH-1:0]           csr_index,
   input  logic [bqf_pkg::COEF_WIDTH-1:0]              csr_wdata
);

   // coefficients
   logic signed [bqf_pkg::COEF_WIDTH-1:0] coef_a1_ff, coef_a2_ff;
   logic signed [bqf_pkg::COEF_WIDTH-1:0] coef_b0_ff, coef_b1_ff, coef_b2_ff;

   // filter state and per-sample working regs
   logic signed [bqf_pkg::STATE_WIDTH-1:0]  w_prev1_ff, w_prev2_ff, w_ff;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] x_ff;
   logic                                    block_end_ff;
   logic                                    clip_ff;

   // output register
   logic                                    rsp_valid_ff;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] rsp_sample_ff;
   logic                                    rsp_block_end_ff;
   logic                                    rsp_clipped_ff;

   bqf_pkg::seq_ctl_type                    ctl;
   logic                                    accept;
   logic                                    out_free;
   logic signed [bqf_pkg::STATE_WIDTH-1:0]  op_a;
   logic signed [bqf_pkg::COEF_WIDTH-1:0]   op_b;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]    acc;
   logic signed [bqf_pkg::RND_WIDTH-1:0]    rnd;
   logic                                    w_sat, y_sat;
   logic signed [bqf_pkg::STATE_WIDTH-1:0]  w_sat_val;
   logic signed [bqf_pkg::SAMPLE_WIDTH-1:0] y_sat_val;

   assign accept   = req_valid & req_ready;
   assign out_free = ~rsp_valid_ff | rsp_ready;

   bqf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .out_free  (out_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   // operand select into the shared multiplier
   always_comb begin
      unique case (ctl.a_sel)
         bqf_pkg::A_X:  op_a = {{(bqf_pkg::STATE_WIDTH-bqf_pkg::SAMPLE_WIDTH)
                                 {x_ff[bqf_pkg::SAMPLE_WIDTH-1]}}, x_ff};
         bqf_pkg::A_W1: op_a = w_prev1_ff;
         bqf_pkg::A_W2: op_a = w_prev2_ff;
         default:       op_a = w_ff;
      endcase
      unique case (ctl.b_sel)
         bqf_pkg::B_ONE: op_b = bqf_pkg::COEF_ONE;
         bqf_pkg::B_A1:  op_b = coef_a1_ff;
         bqf_pkg::B_A2:  op_b = coef_a2_ff;
         bqf_pkg::B_B0:  op_b = coef_b0_ff;
         bqf_pkg::B_B1:  op_b = coef_b1_ff;
         default:        op_b = coef_b2_ff;
      endcase
   end

   bqf_mac u_mac (
      .clock  (clock),
      .op_a   (op_a),
      .op_b   (op_b),
      .acc_op (ctl.acc_op),
      .acc    (acc)
   );

   // round, then clamp to the state range (w) or the sample range (y)
   always_comb begin
      rnd   = bqf_pkg::round_acc(acc);
      w_sat = 1'b0;
      y_sat = 1'b0;
      priority if (rnd > bqf_pkg::W_MAX) begin
         w_sat     = 1'b1;
         w_sat_val = bqf_pkg::W_MAX[bqf_pkg::STATE_WIDTH-1:0];
      end else if (rnd < bqf_pkg::W_MIN) begin
         w_sat     = 1'b1;
         w_sat_val = bqf_pkg::W_MIN[bqf_pkg::STATE_WIDTH-1:0];
      end else begin
         w_sat_val = rnd[bqf_pkg::STATE_WIDTH-1:0];
      end
      priority if (rnd > bqf_pkg::Y_MAX) begin
         y_sat     = 1'b1;
         y_sat_val = bqf_pkg::Y_MAX[bqf_pkg::SAMPLE_WIDTH-1:0];
      end else if (rnd < bqf_pkg::Y_MIN) begin
         y_sat     = 1'b1;
         y_sat_val = bqf_pkg::Y_MIN[bqf_pkg::SAMPLE_WIDTH-1:0];
      end else begin
         y_sat_val = rnd[bqf_pkg::SAMPLE_WIDTH-1:0];
      end
   end

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_a1_ff <= '0;
         coef_a2_ff <= '0;
         coef_b0_ff <= bqf_pkg::COEF_ONE;
         coef_b1_ff <= '0;
         coef_b2_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            bqf_pkg::CSR_A1: coef_a1_ff <= csr_wdata;
            bqf_pkg::CSR_A2: coef_a2_ff <= csr_wdata;
            bqf_pkg::CSR_B0: coef_b0_ff <= csr_wdata;
            bqf_pkg::CSR_B1: coef_b1_ff <= csr_wdata;
            bqf_pkg::CSR_B2: coef_b2_ff <= csr_wdata;
            default: ;  // out-of-range index: dropped
         endcase
      end
   end

   // delay line: shifts once the y sum is done
   always_ff @(posedge clock) begin
      if (reset) begin
         w_prev1_ff <= '0;
         w_prev2_ff <= '0;
      end else if (ctl.y_done) begin
         w_prev1_ff <= w_ff;
         w_prev2_ff <= w_prev1_ff;
      end
   end

   // per-sample working regs (payload, no reset)
   always_ff @(posedge clock) begin
      if (accept) begin
         x_ff         <= req_sample_in;
         block_end_ff <= req_block_end_in;
         clip_ff      <= 1'b0;
      end else if (ctl.w_done) begin
         w_ff    <= w_sat_val;
         clip_ff <= w_sat;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.y_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.y_done) begin
         rsp_sample_ff    <= y_sat_val;
         rsp_block_end_ff <= block_end_ff;
         rsp_clipped_ff   <= clip_ff | y_sat;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_out    = rsp_sample_ff;
   assign rsp_block_end_out = rsp_block_end_ff;
   assign rsp_clipped       = rsp_clipped_ff;

   // ------------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------------
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("request accepted while a sample is in flight");

   a_result_load_free: assert property (@(posedge clock) disable iff (reset)
      ctl.y_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an unread response");

   a_mac_idle_when_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (ctl.acc_op == bqf_pkg::ACC_HOLD && !ctl.w_done))
      else $error("MAC active while sequencer idle");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##11 rsp_valid)
      else $error("response not valid 11 cycles after accept");

endmodule

[sv/bqf_mac.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_mac
// Shared multiply-accumulate: registered product, then accumulator.
// ----------------------------------------------------------------------------
module bqf_mac (
   input  logic                                     clock,
   input  logic signed [bqf_pkg::STATE_WIDTH-1:0]   op_a,
   input  logic signed [bqf_pkg::COEF_WIDTH-1:0]    op_b,
   input  bqf_pkg::acc_op_type                      acc_op,
   output logic signed [bqf_pkg::ACC_WIDTH-1:0]     acc
);

   logic signed [bqf_pkg::PROD_WIDTH-1:0] prod_ff;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]  prod_ext;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]  acc_ff;
   logic signed [bqf_pkg::ACC_WIDTH-1:0]  acc_in;

   assign prod_ext = {{(bqf_pkg::ACC_WIDTH-bqf_pkg::PROD_WIDTH){prod_ff[bqf_pkg::PROD_WIDTH-1]}},
                      prod_ff};

   always_comb begin
      unique case (acc_op)
         bqf_pkg::ACC_LOAD: acc_in = prod_ext;
         bqf_pkg::ACC_ADD:  acc_in = acc_ff + prod_ext;
         bqf_pkg::ACC_SUB:  acc_in = acc_ff - prod_ext;
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

[sv/bqf_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bqf_seq
// Sequencer: steps the shared MAC through the w and y sums of one sample.
// ----------------------------------------------------------------------------
module bqf_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  out_free,
   output logic                  req_ready,
   output bqf_pkg::seq_ctl_type  ctl
);

   bqf_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bqf_pkg::S_IDLE: if (req_valid) state_in = bqf_pkg::S_W0;
         bqf_pkg::S_W0:   state_in = bqf_pkg::S_W1;
         bqf_pkg::S_W1:   state_in = bqf_pkg::S_W2;
         bqf_pkg::S_W2:   state_in = bqf_pkg::S_W3;
         bqf_pkg::S_W3:   state_in = bqf_pkg::S_WR;
         bqf_pkg::S_WR:   state_in = bqf_pkg::S_Y0;
         bqf_pkg::S_Y0:   state_in = bqf_pkg::S_Y1;
         bqf_pkg::S_Y1:   state_in = bqf_pkg::S_Y2;
         bqf_pkg::S_Y2:   state_in = bqf_pkg::S_Y3;
         bqf_pkg::S_Y3:   state_in = bqf_pkg::S_YR;
         bqf_pkg::S_YR:   if (out_free) state_in = bqf_pkg::S_IDLE;
         default:         state_in = bqf_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      req_ready  = 1'b0;
      ctl.a_sel  = bqf_pkg::A_X;
      ctl.b_sel  = bqf_pkg::B_ONE;
      ctl.acc_op = bqf_pkg::ACC_HOLD;
      ctl.w_done = 1'b0;
      ctl.y_done = 1'b0;
      unique case (state_ff)
         bqf_pkg::S_IDLE: req_ready = 1'b1;
         bqf_pkg::S_W0: begin
            ctl.a_sel = bqf_pkg::A_X;
            ctl.b_sel = bqf_pkg::B_ONE;
         end
         bqf_pkg::S_W1: begin
            ctl.a_sel  = bqf_pkg::A_W1;
            ctl.b_sel  = bqf_pkg::B_A1;
            ctl.acc_op = bqf_pkg::ACC_LOAD;
         end
         bqf_pkg::S_W2: begin
            ctl.a_sel  = bqf_pkg::A_W2;
            ctl.b_sel  = bqf_pkg::B_A2;
            ctl.acc_op = bqf_pkg::ACC_SUB;
         end
         bqf_pkg::S_W3:   ctl.acc_op = bqf_pkg::ACC_SUB;
         bqf_pkg::S_WR:   ctl.w_done = 1'b1;
         bqf_pkg::S_Y0: begin
            ctl.a_sel = bqf_pkg::A_W;
            ctl.b_sel = bqf_pkg::B_B0;
         end
         bqf_pkg::S_Y1: begin
            ctl.a_sel  = bqf_pkg::A_W1;
            ctl.b_sel  = bqf_pkg::B_B1;
            ctl.acc_op = bqf_pkg::ACC_LOAD;
         end
         bqf_pkg::S_Y2: begin
            ctl.a_sel  = bqf_pkg::A_W2;
            ctl.b_sel  = bqf_pkg::B_B2;
            ctl.acc_op = bqf_pkg::ACC_ADD;
         end
         bqf_pkg::S_Y3:   ctl.acc_op = bqf_pkg::ACC_ADD;
         bqf_pkg::S_YR:   ctl.y_done = out_free;
         default:         req_ready = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bqf_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
